// File: sv/vkut_pkg.sv
// Package: types, constants and status codes of the versioned keyed upsert table.
`default_nettype none
package vkut_pkg;
	localparam int unsigned ENTRIES_DEF = 64;
	localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
	localparam int unsigned IDX_W = 6;
	localparam logic [2:0] ST_MAX_VALID = 3'd2;

	typedef enum logic [2:0] {
		STAT_ADDED    = 3'd0,
		STAT_UPDATED  = 3'd1,
		STAT_SAME     = 3'd2,
		STAT_INVALID  = 3'd3,
		STAT_STALE    = 3'd4,
		STAT_CONFLICT = 3'd5,
		STAT_FULL     = 3'd6,
		STAT_UNCONF   = 3'd7
	} status_t;

	typedef enum logic [0:0] {
		REG_STREAM = 1'b0,
		REG_CONFIGURED = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_CHECK, S_CMP, S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] delta_stream;
		logic [31:0] node_id;
		logic [31:0] generation;
		logic [31:0] revision;
		logic [2:0]  node_state;
		logic [15:0] remaining_work;
		logic [15:0] max_work;
		logic signed [31:0] deadline_ms;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  status;
		logic [IDX_W-1:0] entry_index;
	} rsp_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] generation;
		logic [31:0] revision;
		logic [2:0]  node_state;
		logic [15:0] remaining;
		logic [15:0] maximum;
		logic [31:0] deadline;
	} entry_t;

	// serial order: 2'b00 equal, 2'b01 newer, 2'b10 older
	function automatic logic [1:0] serial_order(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		if (a == b) return 2'b00;
		if (d == HALF_RANGE) return (a < b) ? 2'b10 : 2'b01;
		return (d < HALF_RANGE) ? 2'b01 : 2'b10;
	endfunction
endpackage
`default_nettype wire

// File: sv/versioned_keyed_upsert_table.sv
// Top level of the versioned keyed upsert table.
// Usage: raise start with a request on req while busy is low; the request is
// taken at that edge and busy stays high until its response has gone out.
// The block scans the table for the key, then compares versions and writes back.
// Exactly one response appears on rsp with done high for one cycle. The receiver
// cannot stall it, so it must take it in that cycle.
// Order of states: a check state follows the accepting edge. Unconfigured or
// invalid requests and requests to an empty table go from it straight to the
// done state. Otherwise each slot visited takes a read state (read address),
// then a compare state (registered read data and compare), for at most
// entry_count slots, and the done state follows the last compare. A new request
// is taken only once busy is low again after the response. The single read port
// of the entry memory and the unpipelined read and compare leave the block with
// one request in flight at a time.
// Configuration: cfg_we with cfg_idx 0 writes the stream register, 1 writes the
// configured flag; write only while busy is low.
// Reset: arst_n clears the state, configuration, scan and done registers, all
// valid bits and the fill count; the table is empty immediately, with no clearing pass.
`default_nettype none
module versioned_keyed_upsert_table import vkut_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_data
);
	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

	logic [31:0] stream_q;
	logic        conf_q;
	req_t        req_q;
	state_t      state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	rsp_t        rsp_q, rsp_d;
	logic        done_q;

	entry_t      rd_data;
	logic        rd_valid;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic        invalid;
	logic        hit;
	logic [1:0]  ord_g, ord_r, ord;
	logic        same;
	logic [AW-1:0] scan_a;

	assign scan_a = scan_q[AW-1:0];

	vkut_store #(.ENTRIES(ENTRIES), .AW(AW)) u_store (
		.clk, .arst_n,
		.rd_addr (scan_a),
		.rd_data, .rd_valid,
		.wr_en, .wr_addr,
		.wr_data ({req_q.node_id, req_q.generation, req_q.revision, req_q.node_state,
			req_q.remaining_work, req_q.max_work, req_q.deadline_ms})
	);

	// Reject malformed requests up front.
	assign invalid = (req_q.delta_stream != stream_q) || (req_q.node_id == '0)
		|| (req_q.generation == '0) || (req_q.revision == '0)
		|| (req_q.node_state > ST_MAX_VALID) || (req_q.remaining_work > req_q.max_work)
		|| req_q.deadline_ms[31];

	assign hit   = rd_valid && (rd_data.key == req_q.node_id);
	assign ord_g = serial_order(req_q.generation, rd_data.generation);
	assign ord_r = serial_order(req_q.revision, rd_data.revision);
	assign ord   = (ord_g == 2'b00) ? ord_r : ord_g;
	assign same  = (rd_data.node_state == req_q.node_state)
		&& (rd_data.remaining == req_q.remaining_work)
		&& (rd_data.maximum == req_q.max_work)
		&& (rd_data.deadline == req_q.deadline_ms);

	function automatic rsp_t mk(input status_t s, input logic [AW-1:0] i);
		rsp_t r;
		r.accepted = (s == STAT_ADDED) || (s == STAT_UPDATED) || (s == STAT_SAME);
		r.status = s;
		r.entry_index = IDX_W'(i);
		return r;
	endfunction

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_CHECK;
			S_CHECK: state_d = (!conf_q || invalid) ? S_DONE
				: (count_q == '0) ? S_DONE : S_READ;
			S_READ:  state_d = S_CMP;
			S_CMP:   state_d = (hit || (scan_q + 1'b1 >= count_q)) ? S_DONE : S_READ;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Response and write-back decisions.
	always_comb begin
		rsp_d   = rsp_q;
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		unique case (state_q)
			S_CHECK: begin
				if (!conf_q) rsp_d = mk(STAT_UNCONF, '0);
				else if (invalid) rsp_d = mk(STAT_INVALID, '0);
				else if (count_q == '0) begin
					rsp_d = mk(STAT_ADDED, '0);
					wr_en = 1'b1;
				end
			end
			S_CMP: begin
				if (hit) begin
					wr_addr = scan_a;
					priority if (req_q.delta_stream == '0) rsp_d = mk(STAT_INVALID, scan_a);
					else if (ord == 2'b00) rsp_d = mk(same ? STAT_SAME : STAT_CONFLICT, scan_a);
					else if (ord == 2'b10) rsp_d = mk(STAT_STALE, scan_a);
					else begin
						rsp_d = mk(STAT_UPDATED, scan_a);
						wr_en = 1'b1;
					end
				end else if (scan_q + 1'b1 >= count_q) begin
					if (count_q == FULL_CNT) rsp_d = mk(STAT_FULL, '0);
					else begin
						rsp_d = mk(STAT_ADDED, count_q[AW-1:0]);
						wr_en = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
		rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			stream_q <= '0;
			conf_q   <= 1'b0;
			count_q  <= '0;
			scan_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_d == S_DONE);
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_STREAM:     stream_q <= cfg_data;
					REG_CONFIGURED: conf_q   <= cfg_data[0];
					default: ;
				endcase
			end
			// Advance the scan pointer after each compare; restart per request.
			if (state_q == S_CHECK) scan_q <= '0;
			else if (state_q == S_CMP) scan_q <= scan_q + 1'b1;
			if (wr_en && wr_addr == count_q[AW-1:0] && rsp_d.status == STAT_ADDED)
				count_q <= count_q + 1'b1;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("fill count beyond table size");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("response strobe longer than one cycle");
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> busy) else $error("table write while idle");
	a_acc_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.accepted == (rsp.status <= STAT_SAME))) else $error("accept flag mismatch");
`endif
endmodule
`default_nettype wire

// File: sv/vkut_store.sv
// Entry store: memory of slot records with registered read and valid bits.
`default_nettype none
module vkut_store import vkut_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data,
	output logic               rd_valid,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  entry_t             wr_data
);
	entry_t mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			rd_valid <= valid_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// File: test/vkut_checker.sv
// Checker: watches request and response channels, predicts table outcomes, compares.
`timescale 1ns / 1ps
`default_nettype none
module vkut_checker import vkut_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  req_t             req,
	input  wire logic        done,
	input  rsp_t             rsp,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               responses_seen
);
	logic [31:0] stream_reg;
	logic        configured;
	logic        slot_valid [ENTRIES_DEF];
	entry_t      slot_data [ENTRIES_DEF];
	int          fill;
	rsp_t        outcome_q [$];

	// wrapped serial compare: 1 newer, -1 older, 0 equal
	function automatic int wrap_cmp(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		if (a == b) return 0;
		if (d == 32'h8000_0000) return (a < b) ? -1 : 1;
		return (d < 32'h8000_0000) ? 1 : -1;
	endfunction

	function automatic rsp_t make_rsp(status_t s, int slot);
		rsp_t r;
		r.accepted = (s == STAT_ADDED || s == STAT_UPDATED || s == STAT_SAME);
		r.status = s;
		r.entry_index = slot[IDX_W-1:0];
		return r;
	endfunction

	// apply one upsert to the shadow table and return its outcome
	function automatic rsp_t apply_upsert(req_t q);
		int hit;
		int ord;
		entry_t e;
		hit = -1;
		if (!configured) return make_rsp(STAT_UNCONF, 0);
		if (q.delta_stream != stream_reg || q.node_id == 0 || q.generation == 0 ||
				q.revision == 0 || q.node_state > ST_MAX_VALID ||
				q.remaining_work > q.max_work || q.deadline_ms[31])
			return make_rsp(STAT_INVALID, 0);
		for (int s = 0; s < ENTRIES_DEF; s++)
			if (hit < 0 && slot_valid[s] && slot_data[s].key == q.node_id) hit = s;
		e = '{q.node_id, q.generation, q.revision, q.node_state, q.remaining_work,
			q.max_work, q.deadline_ms};
		if (hit < 0) begin
			if (fill >= ENTRIES_DEF) return make_rsp(STAT_FULL, 0);
			slot_valid[fill] = 1'b1;
			slot_data[fill] = e;
			fill++;
			return make_rsp(STAT_ADDED, fill - 1);
		end
		if (q.delta_stream == 0) return make_rsp(STAT_INVALID, hit);
		ord = wrap_cmp(q.generation, slot_data[hit].generation);
		if (ord == 0) ord = wrap_cmp(q.revision, slot_data[hit].revision);
		if (ord == 0) begin
			if (slot_data[hit].node_state == q.node_state &&
					slot_data[hit].remaining == q.remaining_work &&
					slot_data[hit].maximum == q.max_work &&
					slot_data[hit].deadline == q.deadline_ms)
				return make_rsp(STAT_SAME, hit);
			return make_rsp(STAT_CONFLICT, hit);
		end
		if (ord < 0) return make_rsp(STAT_STALE, hit);
		slot_data[hit] = e;
		return make_rsp(STAT_UPDATED, hit);
	endfunction

	assign pending = outcome_q.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			stream_reg <= '0;
			configured <= 1'b0;
			fill = 0;
			for (int s = 0; s < ENTRIES_DEF; s++) slot_valid[s] = 1'b0;
			outcome_q.delete();
			fail_count <= 0;
			responses_seen <= 0;
		end else begin
			if (done) begin
				responses_seen <= responses_seen + 1;
				if (outcome_q.size() == 0) begin
					$error("response with no request waiting: %p", rsp);
					fail_count <= fail_count + 1;
				end else begin
					want = outcome_q.pop_front();
					if (rsp.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, rsp.accepted);
						fail_count <= fail_count + 1;
					end else if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count <= fail_count + 1;
					end else if (rsp.entry_index !== want.entry_index) begin
						$error("entry_index: expected %0d, got %0d",
							want.entry_index, rsp.entry_index);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) outcome_q.push_back(apply_upsert(req));
			if (cfg_we) begin
				if (cfg_idx == REG_STREAM) stream_reg <= cfg_data;
				else configured <= cfg_data[0];
			end
		end
	end
endmodule
`default_nettype wire

// File: test/tb_versioned_keyed_upsert_table.sv
// Testbench top: drives upsert requests and register writes, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_versioned_keyed_upsert_table;
	import vkut_pkg::*;

	localparam int WATCHDOG = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = 1'b0;
	logic [31:0] cfg_data = '0;
	int          fail_count, pending, responses_seen;
	int          idle_cycles = 0;
	int          sent;
	logic [31:0] stream_now;
	logic        calm;
	logic [31:0] keys [16];
	req_t        last_good;

	versioned_keyed_upsert_table dut (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp,
		.cfg_we, .cfg_idx, .cfg_data
	);

	vkut_checker chk (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp,
		.cfg_we, .cfg_idx, .cfg_data,
		.fail_count, .pending, .responses_seen
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: count cycles with no accepted request, response or register write
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog expired after %0d quiet cycles", WATCHDOG);
			$display("status: fail");
			$finish;
		end
	end

	// hold one request on the port until it is taken, with a random gap first unless calm
	task automatic push_request(req_t q);
		int gap;
		@(posedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		req <= q;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		sent++;
	endtask

	// write one register; only called once the table has drained
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STREAM) stream_now = val;
	endtask

	// let every outstanding request finish, then allow the scan latency to pass
	task automatic drain();
		while (pending != 0 || busy) @(posedge clk);
		repeat (2 * ENTRIES_DEF + 8) @(posedge clk);
	endtask

	// a well-formed record with random content
	function automatic req_t good_record(logic [31:0] key);
		req_t q;
		logic [15:0] mx;
		mx = 16'($urandom);
		q.delta_stream = stream_now;
		q.node_id = key;
		q.generation = $urandom_range(1, 4);
		q.revision = $urandom_range(1, 4);
		q.node_state = 3'($urandom_range(0, 2));
		q.max_work = mx;
		q.remaining_work = (mx == 0) ? 16'd0 : 16'($urandom_range(0, mx));
		q.deadline_ms = {1'b0, 31'($urandom)};
		return q;
	endfunction

	// random record: mostly valid, a few broken in one field or fully random
	function automatic req_t mixed_record(logic [31:0] key);
		req_t q;
		q = good_record(key);
		case ($urandom_range(0, 19))
			0: q.delta_stream = $urandom;
			1: q.node_id = 0;
			2: q.generation = 0;
			3: q.revision = 0;
			4: q.node_state = 3'($urandom_range(3, 7));
			5: q.deadline_ms = {1'b1, 31'($urandom)};
			6: begin
				q.max_work = 16'($urandom_range(0, 16'hfffe));
				q.remaining_work = 16'($urandom_range(q.max_work + 1, 16'hffff));
			end
			7: q = {$urandom, $urandom, $urandom, $urandom, 3'($urandom), $urandom, $urandom};
			8: begin
				q.generation = $urandom;
				q.revision = $urandom;
				if (q.generation == 0) q.generation = 1;
				if (q.revision == 0) q.revision = 1;
			end
			default: ;
		endcase
		return q;
	endfunction

	// variant of the last sent record: same, conflict, newer, older and half-range
	function automatic req_t version_probe(req_t base);
		req_t q;
		q = base;
		case ($urandom_range(0, 6))
			0: ;
			1: q.deadline_ms = base.deadline_ms ^ 32'h1;
			2: q.revision = base.revision + 1;
			3: q.generation = base.generation - 1;
			4: q.generation = base.generation + 32'h8000_0000;
			5: q.revision = base.revision + 32'h8000_0000;
			6: q.generation = base.generation + 32'h7fff_ffff;
		endcase
		if (q.generation == 0) q.generation = 1;
		if (q.revision == 0) q.revision = 1;
		return q;
	endfunction

	initial begin
		req_t q;
		int phase;
		logic [31:0] streams [4];
		sent = 0;
		calm = 1'b0;
		stream_now = '0;
		streams = '{32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h5a5a_1234};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unconfigured: every record is refused
		push_request(good_record(32'h1));
		push_request('1);
		drain();

		// directed: extremes, invalid fields, half-range tie, zero stream match
		write_reg(REG_STREAM, 32'hffff_ffff);
		write_reg(REG_CONFIGURED, 32'h1);
		q = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 3'd2,
			16'hffff, 16'hffff, 32'sh7fff_ffff};
		push_request(q);
		push_request(q);
		q.remaining_work = 16'h0;
		push_request(q);
		q.generation = 32'h7fff_ffff;
		push_request(q);
		q.generation = 32'h7fff_fffe;
		push_request(q);
		q.revision = 32'h7fff_ffff;
		push_request(q);
		q.generation = 32'h1;
		push_request(q);
		push_request('{32'hffff_ffff, 32'h1, 32'h1, 32'h1, 3'd0, 16'h0, 16'h0, 32'sh0});
		push_request('{32'hffff_fffe, 32'h2, 32'h1, 32'h1, 3'd0, 16'h0, 16'h0, 32'sh0});
		push_request('{32'hffff_ffff, 32'h0, 32'h1, 32'h1, 3'd0, 16'h0, 16'h0, 32'sh0});
		push_request('{32'hffff_ffff, 32'h2, 32'h0, 32'h1, 3'd0, 16'h0, 16'h0, 32'sh0});
		push_request('{32'hffff_ffff, 32'h2, 32'h1, 32'h0, 3'd0, 16'h0, 16'h0, 32'sh0});
		push_request('{32'hffff_ffff, 32'h2, 32'h1, 32'h1, 3'd3, 16'h0, 16'h0, 32'sh0});
		push_request('{32'hffff_ffff, 32'h2, 32'h1, 32'h1, 3'd7, 16'h0, 16'h0, 32'sh0});
		push_request('{32'hffff_ffff, 32'h2, 32'h1, 32'h1, 3'd1, 16'h1, 16'h0, 32'sh0});
		push_request('{32'hffff_ffff, 32'h2, 32'h1, 32'h1, 3'd1, 16'h0, 16'h0,
			-32'sd2147483648});
		drain();
		write_reg(REG_STREAM, 32'h0);
		// zero stream: new key inserted, existing key refused with its slot
		push_request('{32'h0, 32'h1, 32'h5, 32'h5, 3'd0, 16'h0, 16'h0, 32'sh0});
		push_request('{32'h0, 32'h3, 32'h5, 32'h5, 3'd0, 16'h0, 16'h0, 32'sh0});
		drain();

		// random phases with several stream settings; small key pool forces hits
		for (phase = 0; phase < 8; phase++) begin
			write_reg(REG_STREAM, (phase < 4) ? streams[phase] : $urandom);
			write_reg(REG_CONFIGURED, (phase == 5) ? 32'h0 : 32'hffff_fffe | 32'h1);
			for (int k = 0; k < 16; k++) keys[k] = (phase[0]) ? $urandom : 32'(k + 1);
			calm = (phase == 7);
			last_good = good_record(keys[0]);
			for (int n = 0; n < 210; n++) begin
				if ($urandom_range(0, 2) == 0) q = version_probe(last_good);
				else if (phase >= 6 && $urandom_range(0, 1) == 0) q = good_record($urandom);
				else q = mixed_record(keys[$urandom_range(0, 15)]);
				push_request(q);
				last_good = q;
			end
			drain();
		end
		// fill the table past its size to hit the full case, then stop
		write_reg(REG_CONFIGURED, 32'h1);
		for (int n = 0; n < 80; n++) push_request(good_record($urandom | 32'h1));
		drain();

		$display("covered %0d requests, %0d responses across unconfigured, invalid,",
			sent, responses_seen);
		$display("insert, update, duplicate, stale and full cases");
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
